// ===== hdl/s2u_pkg.sv =====
package s2u_pkg;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO_AUTO,
      PH_ZERO_FIXED,
      PH_DIGITS,
      PH_STOPPED
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_2,
      RADIX_8,
      RADIX_10,
      RADIX_16
   } radix_type;

   typedef struct packed {
      phase_type   phase;
      logic        negative;
      radix_type   radix;
      logic [63:0] acc;
   } parse_state_type;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_UPPER_B = 8'h42;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;

   localparam logic [4:0] MODE_AUTO = 5'd0;
   localparam logic [4:0] MODE_BIN  = 5'd2;
   localparam logic [4:0] MODE_OCT  = 5'd8;
   localparam logic [4:0] MODE_DEC  = 5'd10;
   localparam logic [4:0] MODE_HEX  = 5'd16;

   localparam logic [4:0] DIGIT_NONE = 5'd16;

   localparam parse_state_type STATE_CLEAR = '{
      phase:    PH_SPACE,
      negative: 1'b0,
      radix:    RADIX_2,
      acc:      64'd0
   };

   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = DIGIT_NONE;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         d = 5'(c - CH_ZERO);
      end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
         d = 5'(c - CH_LOWER_A) + 5'd10;
      end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
         d = 5'(c - CH_UPPER_A) + 5'd10;
      end
      return d;
   endfunction

   function automatic logic [4:0] radix_value(input radix_type r);
      logic [4:0] v;
      case (r)
         RADIX_2:  v = MODE_BIN;
         RADIX_8:  v = MODE_OCT;
         RADIX_10: v = MODE_DEC;
         RADIX_16: v = MODE_HEX;
         default:  v = MODE_HEX;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/s2u_step.sv =====
module s2u_step (
   input  s2u_pkg::parse_state_type cur,
   input  logic [7:0]               ch,
   input  logic [4:0]               radix_mode,
   output s2u_pkg::parse_state_type nxt,
   output logic                     is_end,
   output logic [63:0]              value
);

   logic                mode_auto;
   logic                mode_ok;
   s2u_pkg::radix_type  mode_radix;
   logic                first;
   logic                take;
   logic [4:0]          digit;
   logic [63:0]         scaled;
   s2u_pkg::parse_state_type upd;

   always_comb begin
      mode_auto  = (radix_mode == s2u_pkg::MODE_AUTO);
      mode_ok    = 1'b1;
      mode_radix = s2u_pkg::RADIX_2;
      case (radix_mode)
         s2u_pkg::MODE_BIN: mode_radix = s2u_pkg::RADIX_2;
         s2u_pkg::MODE_OCT: mode_radix = s2u_pkg::RADIX_8;
         s2u_pkg::MODE_DEC: mode_radix = s2u_pkg::RADIX_10;
         s2u_pkg::MODE_HEX: mode_radix = s2u_pkg::RADIX_16;
         default:           mode_ok    = 1'b0;
      endcase
   end

   // phase decode
   always_comb begin
      upd   = cur;
      first = 1'b0;
      take  = 1'b0;
      case (cur.phase)
         s2u_pkg::PH_SPACE: begin
            if (ch == s2u_pkg::CH_SPACE || ch inside {[s2u_pkg::CH_TAB:s2u_pkg::CH_CR]}) begin
               upd.phase = s2u_pkg::PH_SPACE;
            end else if (ch == s2u_pkg::CH_MINUS) begin
               upd.negative = 1'b1;
               upd.phase    = s2u_pkg::PH_SIGNED;
            end else if (ch == s2u_pkg::CH_PLUS) begin
               upd.phase = s2u_pkg::PH_SIGNED;
            end else begin
               first = 1'b1;
            end
         end
         s2u_pkg::PH_SIGNED: begin
            first = 1'b1;
         end
         s2u_pkg::PH_ZERO_AUTO: begin
            if (ch == s2u_pkg::CH_LOWER_X || ch == s2u_pkg::CH_UPPER_X) begin
               upd.radix = s2u_pkg::RADIX_16;
               upd.phase = s2u_pkg::PH_DIGITS;
            end else if (ch == s2u_pkg::CH_LOWER_B || ch == s2u_pkg::CH_UPPER_B) begin
               upd.radix = s2u_pkg::RADIX_2;
               upd.phase = s2u_pkg::PH_DIGITS;
            end else begin
               upd.radix = s2u_pkg::RADIX_8;
               take      = 1'b1;
            end
         end
         s2u_pkg::PH_ZERO_FIXED: begin
            if (cur.radix == s2u_pkg::RADIX_16 &&
                (ch == s2u_pkg::CH_LOWER_X || ch == s2u_pkg::CH_UPPER_X)) begin
               upd.phase = s2u_pkg::PH_DIGITS;
            end else if (cur.radix == s2u_pkg::RADIX_2 &&
                         (ch == s2u_pkg::CH_LOWER_B || ch == s2u_pkg::CH_UPPER_B)) begin
               upd.phase = s2u_pkg::PH_DIGITS;
            end else begin
               take = 1'b1;
            end
         end
         s2u_pkg::PH_DIGITS: begin
            take = 1'b1;
         end
         default: begin
            upd.phase = s2u_pkg::PH_STOPPED;
         end
      endcase

      // first character after blanks and sign latches the radix
      if (first) begin
         if (!mode_auto && !mode_ok) begin
            upd.phase = s2u_pkg::PH_STOPPED;
         end else if (ch == s2u_pkg::CH_ZERO) begin
            upd.radix = mode_auto ? s2u_pkg::RADIX_2 : mode_radix;
            upd.phase = mode_auto ? s2u_pkg::PH_ZERO_AUTO : s2u_pkg::PH_ZERO_FIXED;
         end else begin
            upd.radix = mode_auto ? s2u_pkg::RADIX_10 : mode_radix;
            take      = 1'b1;
         end
      end
   end

   // digit accumulate: multiply by the radix as shifts (and an add for radix 10)
   always_comb begin
      digit = s2u_pkg::digit_value(ch);
      case (upd.radix)
         s2u_pkg::RADIX_2:  scaled = {cur.acc[62:0], 1'b0};
         s2u_pkg::RADIX_8:  scaled = {cur.acc[60:0], 3'b000};
         s2u_pkg::RADIX_10: scaled = {cur.acc[60:0], 3'b000} + {cur.acc[62:0], 1'b0};
         s2u_pkg::RADIX_16: scaled = {cur.acc[59:0], 4'b0000};
         default:           scaled = {cur.acc[59:0], 4'b0000};
      endcase
   end

   always_comb begin
      is_end = (ch == s2u_pkg::CH_NUL);
      value  = cur.negative ? (64'd0 - cur.acc) : cur.acc;
      nxt    = upd;
      if (is_end) begin
         nxt = s2u_pkg::STATE_CLEAR;
      end else if (take) begin
         if (digit < s2u_pkg::radix_value(upd.radix)) begin
            nxt.acc   = scaled + {59'd0, digit};
            nxt.phase = s2u_pkg::PH_DIGITS;
         end else begin
            nxt.phase = s2u_pkg::PH_STOPPED;
         end
      end
   end

endmodule

// ===== hdl/string_to_u64_radix_parser.sv =====
// Streaming ASCII-to-integer parser: one character beat per cycle, sustained.
// The result of a NUL beat passes through the input register and then the
// output register before it shows on rsp_*. Each beat goes into an input
// register and is folded into the parse state by one pass of shift-add logic;
// a NUL beat loads the 64-bit value into the output register and clears the
// parse state. Only a NUL beat can stall, and only while the previous result
// is still held unclaimed in the output register. radix_mode (csr_wdata) is
// sampled at the first character after blanks and sign.
module string_to_u64_radix_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   logic                     in_valid_ff;
   logic [7:0]               in_ch_ff;
   logic [4:0]               radix_mode_ff;
   s2u_pkg::parse_state_type state_ff;
   s2u_pkg::parse_state_type state_in;
   logic                     rsp_valid_ff;
   logic [63:0]              rsp_value_ff;
   logic                     is_end;
   logic [63:0]              end_value;
   logic                     step_fire;

   s2u_step u_step (
      .cur        (state_ff),
      .ch         (in_ch_ff),
      .radix_mode (radix_mode_ff),
      .nxt        (state_in),
      .is_end     (is_end),
      .value      (end_value)
   );

   // a NUL beat needs a free output slot; anything else always advances
   assign step_fire = in_valid_ff && (!is_end || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_mode_ff <= s2u_pkg::MODE_AUTO;
      end else if (csr_we) begin
         radix_mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ch_ff <= req_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s2u_pkg::STATE_CLEAR;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire && is_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && is_end) begin
         rsp_value_ff <= end_value;
      end
   end

   a_stall_only_on_held_result : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && is_end && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a held result");

   a_end_clears_state : assert property (@(posedge clock) disable iff (reset)
      (step_fire && is_end) |=> (rsp_valid_ff && state_ff.phase == s2u_pkg::PH_SPACE &&
                                 !state_ff.negative && state_ff.acc == 64'd0))
      else $error("string end did not post result and clear state");

   a_space_is_clean : assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == s2u_pkg::PH_SPACE) |-> (!state_ff.negative && state_ff.acc == 64'd0))
      else $error("blank phase with leftover sign or value");

endmodule

// ===== tb/sv/tb_string_to_u64_radix_parser.sv =====
module tb_string_to_u64_radix_parser;

   localparam int RANDOM_ITEMS   = 1050;
   localparam int QUIET_ITEMS    = 200;
   localparam int STRINGS_PER_MODE = 12;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 250;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;

   // radix settings the block must treat as unsupported
   localparam logic [4:0] MODE_ODD = 5'd3;
   localparam logic [4:0] MODE_TOP = 5'd31;

   typedef struct packed {
      logic        known;
      logic [63:0] value;
   } result_tag_type;

   typedef struct {
      logic [4:0]  mode;
      string       text;
      int          split;
      logic [4:0]  mode2;
      bit          known;
      logic [63:0] value;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_ch = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_value;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = 5'd0;

   string_to_u64_radix_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_ch    (req_ch),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // string parser mirror
   logic [4:0]          p_mode  = s2u_pkg::MODE_AUTO;
   s2u_pkg::phase_type  p_phase = s2u_pkg::PH_SPACE;
   logic                p_neg   = 1'b0;
   s2u_pkg::radix_type  p_radix = s2u_pkg::RADIX_2;
   logic [63:0]         p_acc   = 64'd0;

   logic [63:0]    parsed_values_q [$];
   result_tag_type known_values_q [$];
   logic [7:0]     pending_chars [$];
   int             err_count = 0;
   logic [4:0]     cur_mode = s2u_pkg::MODE_AUTO;
   logic           hold_req = 1'b0;
   logic           quiet = 1'b0;

   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if (c >= s2u_pkg::CH_ZERO && c <= s2u_pkg::CH_NINE) return 5'(c - s2u_pkg::CH_ZERO);
      if (folded >= s2u_pkg::CH_LOWER_A && folded <= s2u_pkg::CH_LOWER_F)
         return 5'(folded - s2u_pkg::CH_LOWER_A + 8'd10);
      return s2u_pkg::DIGIT_NONE;
   endfunction

   task automatic take_digit(input logic [7:0] c);
      logic [4:0] d;
      logic [4:0] base;
      d = digit_of(c);
      case (p_radix)
         s2u_pkg::RADIX_2:  base = 5'd2;
         s2u_pkg::RADIX_8:  base = 5'd8;
         s2u_pkg::RADIX_10: base = 5'd10;
         default:           base = 5'd16;
      endcase
      if (d < base) begin
         p_acc = p_acc * 64'(base) + 64'(d);
         p_phase = s2u_pkg::PH_DIGITS;
      end else begin
         p_phase = s2u_pkg::PH_STOPPED;
      end
   endtask

   // latch the radix at the first character past blanks and sign
   task automatic first_char(input logic [7:0] c);
      bit                 supported;
      s2u_pkg::radix_type code;
      supported = 1'b1;
      code = s2u_pkg::RADIX_2;
      case (p_mode)
         s2u_pkg::MODE_BIN: code = s2u_pkg::RADIX_2;
         s2u_pkg::MODE_OCT: code = s2u_pkg::RADIX_8;
         s2u_pkg::MODE_DEC: code = s2u_pkg::RADIX_10;
         s2u_pkg::MODE_HEX: code = s2u_pkg::RADIX_16;
         default:           supported = 1'b0;
      endcase
      if (p_mode != s2u_pkg::MODE_AUTO && !supported) begin
         p_phase = s2u_pkg::PH_STOPPED;
      end else if (c == s2u_pkg::CH_ZERO) begin
         if (p_mode == s2u_pkg::MODE_AUTO) begin
            p_phase = s2u_pkg::PH_ZERO_AUTO;
         end else begin
            p_radix = code;
            p_phase = s2u_pkg::PH_ZERO_FIXED;
         end
      end else begin
         p_radix = (p_mode == s2u_pkg::MODE_AUTO) ? s2u_pkg::RADIX_10 : code;
         take_digit(c);
      end
   endtask

   task automatic parse_char(input logic [7:0] c, output bit ended, output logic [63:0] v);
      bit is_x;
      bit is_b;
      ended = 1'b0;
      v = 64'd0;
      is_x = (c == s2u_pkg::CH_LOWER_X || c == s2u_pkg::CH_UPPER_X);
      is_b = (c == s2u_pkg::CH_LOWER_B || c == s2u_pkg::CH_UPPER_B);
      if (c == s2u_pkg::CH_NUL) begin
         ended = 1'b1;
         v = p_neg ? (64'd0 - p_acc) : p_acc;
         p_phase = s2u_pkg::PH_SPACE;
         p_neg = 1'b0;
         p_radix = s2u_pkg::RADIX_2;
         p_acc = 64'd0;
      end else begin
         case (p_phase)
            s2u_pkg::PH_SPACE: begin
               if (c == s2u_pkg::CH_SPACE ||
                   (c >= s2u_pkg::CH_TAB && c <= s2u_pkg::CH_CR)) begin
                  // stay in leading blanks
               end else if (c == s2u_pkg::CH_MINUS) begin
                  p_neg = 1'b1;
                  p_phase = s2u_pkg::PH_SIGNED;
               end else if (c == s2u_pkg::CH_PLUS) begin
                  p_phase = s2u_pkg::PH_SIGNED;
               end else begin
                  first_char(c);
               end
            end
            s2u_pkg::PH_SIGNED: first_char(c);
            s2u_pkg::PH_ZERO_AUTO: begin
               if (is_x) begin
                  p_radix = s2u_pkg::RADIX_16;
                  p_phase = s2u_pkg::PH_DIGITS;
               end else if (is_b) begin
                  p_radix = s2u_pkg::RADIX_2;
                  p_phase = s2u_pkg::PH_DIGITS;
               end else begin
                  p_radix = s2u_pkg::RADIX_8;
                  take_digit(c);
               end
            end
            s2u_pkg::PH_ZERO_FIXED: begin
               if ((p_radix == s2u_pkg::RADIX_16 && is_x) ||
                   (p_radix == s2u_pkg::RADIX_2 && is_b)) begin
                  p_phase = s2u_pkg::PH_DIGITS;
               end else begin
                  take_digit(c);
               end
            end
            s2u_pkg::PH_DIGITS: take_digit(c);
            default: p_phase = s2u_pkg::PH_STOPPED;
         endcase
      end
   endtask

   always @(posedge clock) begin : watch_ports
      logic [63:0]    want;
      logic [63:0]    got;
      bit             ended;
      result_tag_type tag;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (parsed_values_q.size() == 0) begin
               if (err_count < REPORT_LIMIT)
                  $display("unexpected result: value=%h", rsp_value);
               err_count++;
            end else begin
               want = parsed_values_q.pop_front();
               if (rsp_value !== want) begin
                  if (err_count < REPORT_LIMIT)
                     $display("value mismatch: expected=%h actual=%h", want, rsp_value);
                  err_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            parse_char(req_ch, ended, got);
            if (ended) begin
               tag = known_values_q.pop_front();
               parsed_values_q.push_back(tag.known ? tag.value : got);
            end
         end
         if (csr_we) p_mode = csr_wdata;
      end
   end

   // receiver: short random stalls, one long hold-off on request
   int  stall_left = 0;
   int  hold_left = 0;
   bit  hold_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_ch(input logic [7:0] c);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic finish_string(input bit known, input logic [63:0] value);
      known_values_q.push_back('{known: known, value: value});
      send_ch(s2u_pkg::CH_NUL);
   endtask

   // drain, let any in-flight character land, then write the radix register
   task automatic set_mode(input logic [4:0] m);
      req_valid <= 1'b0;
      @(posedge clock);
      while (parsed_values_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_mode = m;
   endtask

   function automatic logic [7:0] digit_char(input int d);
      if (d < 10) return s2u_pkg::CH_ZERO + 8'(d);
      return ($urandom_range(0, 1) ? s2u_pkg::CH_LOWER_A : s2u_pkg::CH_UPPER_A) + 8'(d - 10);
   endfunction

   task automatic build_string(input logic [4:0] m);
      int base;
      int n;
      int top;
      pending_chars.delete();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(0, 6)) pending_chars.push_back(8'($urandom_range(1, 255)));
         return;
      end
      repeat ($urandom_range(0, 2))
         pending_chars.push_back($urandom_range(0, 2) == 0 ? s2u_pkg::CH_SPACE
                                                          : 8'($urandom_range(9, 13)));
      case ($urandom_range(0, 5))
         0: pending_chars.push_back(s2u_pkg::CH_MINUS);
         1: pending_chars.push_back(s2u_pkg::CH_PLUS);
         2: begin
            pending_chars.push_back($urandom_range(0, 1) ? s2u_pkg::CH_MINUS : s2u_pkg::CH_PLUS);
            pending_chars.push_back($urandom_range(0, 1) ? s2u_pkg::CH_MINUS : s2u_pkg::CH_PLUS);
         end
         default: ;
      endcase
      case (m)
         s2u_pkg::MODE_BIN: base = 2;
         s2u_pkg::MODE_OCT: base = 8;
         s2u_pkg::MODE_DEC: base = 10;
         s2u_pkg::MODE_HEX: base = 16;
         default: begin
            case ($urandom_range(0, 3))
               0: base = 2;
               1: base = 8;
               2: base = 10;
               default: base = 16;
            endcase
         end
      endcase
      if ((m == s2u_pkg::MODE_AUTO || m == s2u_pkg::MODE_HEX) && base == 16 &&
          $urandom_range(0, 1)) begin
         pending_chars.push_back(s2u_pkg::CH_ZERO);
         pending_chars.push_back($urandom_range(0, 1) ? s2u_pkg::CH_LOWER_X
                                                      : s2u_pkg::CH_UPPER_X);
      end
      if ((m == s2u_pkg::MODE_AUTO || m == s2u_pkg::MODE_BIN) && base == 2 &&
          $urandom_range(0, 1)) begin
         pending_chars.push_back(s2u_pkg::CH_ZERO);
         pending_chars.push_back($urandom_range(0, 1) ? s2u_pkg::CH_LOWER_B
                                                      : s2u_pkg::CH_UPPER_B);
      end
      if (m == s2u_pkg::MODE_AUTO && base == 8) pending_chars.push_back(s2u_pkg::CH_ZERO);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
      repeat (n) begin
         // now and then a digit outside the radix
         top = ($urandom_range(0, 15) == 0) ? 15 : base - 1;
         pending_chars.push_back(digit_char($urandom_range(0, top)));
      end
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) pending_chars.push_back(8'($urandom_range(1, 255)));
   endtask

   dir_row_type dir_rows [25] = '{
      '{s2u_pkg::MODE_AUTO, "", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{s2u_pkg::MODE_AUTO, "12345", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd12345},
      '{s2u_pkg::MODE_AUTO, "\011\012\013\014\015 -7", -1, s2u_pkg::MODE_AUTO,
        1'b1, 64'hFFFF_FFFF_FFFF_FFF9},
      '{s2u_pkg::MODE_AUTO, "0x1fA", -1, s2u_pkg::MODE_AUTO, 1'b0, 64'd0},
      '{s2u_pkg::MODE_AUTO, "+0B101", -1, s2u_pkg::MODE_AUTO, 1'b0, 64'd0},
      '{s2u_pkg::MODE_AUTO, "0777", -1, s2u_pkg::MODE_AUTO, 1'b0, 64'd0},
      '{s2u_pkg::MODE_AUTO, "089", -1, s2u_pkg::MODE_AUTO, 1'b0, 64'd0},
      '{s2u_pkg::MODE_AUTO, "18446744073709551615", -1, s2u_pkg::MODE_AUTO,
        1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{s2u_pkg::MODE_AUTO, "-18446744073709551616", -1, s2u_pkg::MODE_AUTO,
        1'b0, 64'd0},
      '{s2u_pkg::MODE_AUTO, "0x", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{s2u_pkg::MODE_AUTO, "-", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{s2u_pkg::MODE_AUTO, "\010 5", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{s2u_pkg::MODE_AUTO, "\016\377\200", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{s2u_pkg::MODE_HEX, "0xffffffffffffffff", -1, s2u_pkg::MODE_AUTO,
        1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{s2u_pkg::MODE_HEX, "0b1", -1, s2u_pkg::MODE_AUTO, 1'b0, 64'd0},
      '{s2u_pkg::MODE_HEX, "-0X8000000000000000DEADbeef", -1, s2u_pkg::MODE_AUTO,
        1'b0, 64'd0},
      '{s2u_pkg::MODE_BIN, "0b1011x1", -1, s2u_pkg::MODE_AUTO, 1'b0, 64'd0},
      '{s2u_pkg::MODE_BIN, "0x1", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{s2u_pkg::MODE_OCT, "  -0123456789", -1, s2u_pkg::MODE_AUTO, 1'b0, 64'd0},
      '{s2u_pkg::MODE_DEC, "+-5", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{s2u_pkg::MODE_DEC, "12z99", -1, s2u_pkg::MODE_AUTO, 1'b0, 64'd0},
      '{MODE_ODD, "123", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{MODE_TOP, "1", -1, s2u_pkg::MODE_AUTO, 1'b1, 64'd0},
      '{s2u_pkg::MODE_DEC, "1f", 1, s2u_pkg::MODE_HEX, 1'b0, 64'd0},
      '{s2u_pkg::MODE_AUTO, "  Ff", 2, s2u_pkg::MODE_HEX, 1'b0, 64'd0}
   };

   initial begin : drive_requests
      int          sent;
      int          mode_round;
      logic [4:0]  m;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode != cur_mode) set_mode(dir_rows[i].mode);
         for (int k = 0; k < dir_rows[i].text.len(); k++) begin
            // rewrite the register mid-string: the latched radix must hold
            if (k == dir_rows[i].split) set_mode(dir_rows[i].mode2);
            send_ch(dir_rows[i].text[k]);
         end
         finish_string(dir_rows[i].known, dir_rows[i].value);
      end

      sent = 0;
      mode_round = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1:    m = s2u_pkg::MODE_AUTO;
            2:       m = s2u_pkg::MODE_BIN;
            3:       m = s2u_pkg::MODE_OCT;
            4, 5:    m = s2u_pkg::MODE_DEC;
            6, 7:    m = s2u_pkg::MODE_HEX;
            8:       m = MODE_TOP;
            default: m = 5'($urandom_range(0, 31));
         endcase
         set_mode(m);
         for (int s = 0; s < STRINGS_PER_MODE && sent < RANDOM_ITEMS; s++) begin
            if (mode_round == 1 && s == 2) hold_req <= 1'b1;
            if (sent > RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
            build_string(m);
            foreach (pending_chars[j]) send_ch(pending_chars[j]);
            sent += pending_chars.size() + 1;
            finish_string(1'b0, 64'd0);
         end
         mode_round++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (parsed_values_q.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
